// ===== rtl/rqn_pkg.sv =====
// types, coefficients and helpers for the rgb quad to nv21 converter
package rqn_pkg;

  typedef logic [7:0] byte_t;

  // bt.601 full range coefficients in 16-bit fixed point
  localparam logic [15:0] COEF_Y_R  = 16'd19595;
  localparam logic [15:0] COEF_Y_G  = 16'd38470;
  localparam logic [15:0] COEF_Y_B  = 16'd7471;
  localparam logic [15:0] COEF_CB_R = 16'd11059;
  localparam logic [15:0] COEF_CB_G = 16'd21709;
  localparam logic [15:0] COEF_CR_G = 16'd27439;
  localparam logic [15:0] COEF_CR_B = 16'd5329;
  localparam logic [23:0] ROUND_HALF = 24'd32768;
  localparam logic signed [9:0] CHROMA_OFFSET = 10'sd128;

  typedef struct packed {
    byte_t r;
    byte_t g;
    byte_t b;
  } rgb_t;

  // per pixel products, plus the bytes that only need a shift
  typedef struct packed {
    logic [23:0] yr;
    logic [23:0] yg;
    logic [23:0] yb;
    logic [23:0] cbr;
    logic [23:0] cbg;
    logic [23:0] crg;
    logic [23:0] crb;
    byte_t       r;
    byte_t       b;
  } prod_t;

  // per pixel luma byte and rounded chroma terms
  typedef struct packed {
    byte_t             y;
    logic signed [8:0] cb;
    logic signed [8:0] cr;
  } pix_term_t;

  // clamp a signed value to 0..255
  function automatic byte_t clamp_byte(input logic signed [9:0] v);
    byte_t res;
    if (v[9]) begin
      res = 8'd0;
    end else if (v[8]) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/rqn_quad_if.sv =====
// valid/ready channel carrying one 2x2 rgb pixel quad
interface rqn_quad_if;
  logic           valid;
  logic           ready;
  rqn_pkg::byte_t red_top_left;
  rqn_pkg::byte_t green_top_left;
  rqn_pkg::byte_t blue_top_left;
  rqn_pkg::byte_t red_top_right;
  rqn_pkg::byte_t green_top_right;
  rqn_pkg::byte_t blue_top_right;
  rqn_pkg::byte_t red_bottom_left;
  rqn_pkg::byte_t green_bottom_left;
  rqn_pkg::byte_t blue_bottom_left;
  rqn_pkg::byte_t red_bottom_right;
  rqn_pkg::byte_t green_bottom_right;
  rqn_pkg::byte_t blue_bottom_right;

  modport source (
    output valid,
    input  ready,
    output red_top_left, green_top_left, blue_top_left,
    output red_top_right, green_top_right, blue_top_right,
    output red_bottom_left, green_bottom_left, blue_bottom_left,
    output red_bottom_right, green_bottom_right, blue_bottom_right
  );

  modport sink (
    input  valid,
    output ready,
    input  red_top_left, green_top_left, blue_top_left,
    input  red_top_right, green_top_right, blue_top_right,
    input  red_bottom_left, green_bottom_left, blue_bottom_left,
    input  red_bottom_right, green_bottom_right, blue_bottom_right
  );
endinterface

// ===== rtl/rqn_nv21_if.sv =====
// valid/ready channel carrying four luma bytes and one v,u pair
interface rqn_nv21_if;
  logic           valid;
  logic           ready;
  rqn_pkg::byte_t luma_top_left;
  rqn_pkg::byte_t luma_top_right;
  rqn_pkg::byte_t luma_bottom_left;
  rqn_pkg::byte_t luma_bottom_right;
  rqn_pkg::byte_t chroma_v;
  rqn_pkg::byte_t chroma_u;

  modport source (
    output valid,
    input  ready,
    output luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    output chroma_v, chroma_u
  );

  modport sink (
    input  valid,
    output ready,
    input  luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    input  chroma_v, chroma_u
  );
endinterface

// ===== rtl/rgb_quad_to_nv21.sv =====
// rgb 2x2 quad to nv21 luma and v,u pair, three register stages
// path from quad transfer to result valid: products, per-pixel sums, chroma
//   average and clamp into the output register
// throughput: one quad per cycle; each stage advances when the next is empty
//   or moving, so a stall at the output holds every stage once all are full
// reset: synchronous rst clears all stage valid bits, payload is not reset
module rgb_quad_to_nv21 (
  input  logic       clk,
  input  logic       rst,
  rqn_quad_if.sink   quad,
  rqn_nv21_if.source nv21
);

  rqn_pkg::rgb_t      pix [4];
  rqn_pkg::prod_t     s1 [4];
  rqn_pkg::pix_term_t s2_term_next [4];
  rqn_pkg::pix_term_t s2 [4];
  logic               s1_valid;
  logic               s2_valid;
  logic               out_valid;
  logic               s1_ready;
  logic               s2_ready;
  logic               out_ready;
  logic signed [10:0] cb_sum;
  logic signed [10:0] cr_sum;
  logic signed [9:0]  cb_biased;
  logic signed [9:0]  cr_biased;
  rqn_pkg::byte_t     luma [4];
  rqn_pkg::byte_t     chroma_v;
  rqn_pkg::byte_t     chroma_u;

  // stage handshake chain
  assign out_ready  = !out_valid || nv21.ready;
  assign s2_ready   = !s2_valid || out_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign quad.ready = s1_ready;

  // unpack the quad in raster order
  assign pix[0] = '{r: quad.red_top_left, g: quad.green_top_left, b: quad.blue_top_left};
  assign pix[1] = '{r: quad.red_top_right, g: quad.green_top_right,
                    b: quad.blue_top_right};
  assign pix[2] = '{r: quad.red_bottom_left, g: quad.green_bottom_left,
                    b: quad.blue_bottom_left};
  assign pix[3] = '{r: quad.red_bottom_right, g: quad.green_bottom_right,
                    b: quad.blue_bottom_right};

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= quad.valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (out_ready) out_valid <= s2_valid;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_pix
    logic [23:0]        y_sum;
    logic signed [25:0] cb_full;
    logic signed [25:0] cr_full;

    // stage 1: constant multiplies
    always_ff @(posedge clk) begin
      if (s1_ready && quad.valid) begin
        s1[i].yr  <= 24'(rqn_pkg::COEF_Y_R) * 24'(pix[i].r);
        s1[i].yg  <= 24'(rqn_pkg::COEF_Y_G) * 24'(pix[i].g);
        s1[i].yb  <= 24'(rqn_pkg::COEF_Y_B) * 24'(pix[i].b);
        s1[i].cbr <= 24'(rqn_pkg::COEF_CB_R) * 24'(pix[i].r);
        s1[i].cbg <= 24'(rqn_pkg::COEF_CB_G) * 24'(pix[i].g);
        s1[i].crg <= 24'(rqn_pkg::COEF_CR_G) * 24'(pix[i].g);
        s1[i].crb <= 24'(rqn_pkg::COEF_CR_B) * 24'(pix[i].b);
        s1[i].r   <= pix[i].r;
        s1[i].b   <= pix[i].b;
      end
    end

    // stage 2: per pixel sums with rounding, floor shift by 16
    // luma never exceeds 255 since the coefficients sum to one
    always_comb begin
      y_sum   = s1[i].yr + s1[i].yg + s1[i].yb + rqn_pkg::ROUND_HALF;
      cb_full = $signed({3'b000, s1[i].b, 15'b0}) + 26'sd32768
              - $signed({2'b00, s1[i].cbr}) - $signed({2'b00, s1[i].cbg});
      cr_full = $signed({3'b000, s1[i].r, 15'b0}) + 26'sd32768
              - $signed({2'b00, s1[i].crg}) - $signed({2'b00, s1[i].crb});
      s2_term_next[i].y  = y_sum[23:16];
      s2_term_next[i].cb = cb_full[24:16];
      s2_term_next[i].cr = cr_full[24:16];
    end

    always_ff @(posedge clk) begin
      if (s2_ready && s1_valid) begin
        s2[i] <= s2_term_next[i];
      end
    end
  end

  // stage 3: sum four chroma terms, floor divide by 4, offset and clamp; luma passes to the output register
  always_comb begin
    cb_sum = 11'(s2[0].cb) + 11'(s2[1].cb) + 11'(s2[2].cb) + 11'(s2[3].cb);
    cr_sum = 11'(s2[0].cr) + 11'(s2[1].cr) + 11'(s2[2].cr) + 11'(s2[3].cr);
    cb_biased = $signed({cb_sum[10], cb_sum[10:2]}) + rqn_pkg::CHROMA_OFFSET;
    cr_biased = $signed({cr_sum[10], cr_sum[10:2]}) + rqn_pkg::CHROMA_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid) begin
      luma[0]  <= s2[0].y;
      luma[1]  <= s2[1].y;
      luma[2]  <= s2[2].y;
      luma[3]  <= s2[3].y;
      chroma_v <= rqn_pkg::clamp_byte(cr_biased);
      chroma_u <= rqn_pkg::clamp_byte(cb_biased);
    end
  end

  // output channel
  assign nv21.valid             = out_valid;
  assign nv21.luma_top_left     = luma[0];
  assign nv21.luma_top_right    = luma[1];
  assign nv21.luma_bottom_left  = luma[2];
  assign nv21.luma_bottom_right = luma[3];
  assign nv21.chroma_v          = chroma_v;
  assign nv21.chroma_u          = chroma_u;

endmodule
